>>> rtl/cfma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfma_pkg
// Shared types, codes and the prefix mask helper of the CIDR rule matcher.
// ----------------------------------------------------------------------------
package cfma_pkg;

  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_ADD   = 1'b1;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_PREFIX    = 2'd2;
  localparam logic [1:0] STATUS_BAD_ADDR  = 2'd3;

  localparam logic [7:0] FULL_LEN_V4 = 8'd32;
  localparam logic [7:0] FULL_LEN_V6 = 8'd128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_e;

  // One table entry; the network is stored already masked.
  typedef struct packed {
    logic [63:0] net_high;
    logic [63:0] net_low;
    logic [7:0]  prefix;
    logic        is_v6;
    logic        action;
  } rule_t;

  typedef struct packed {
    logic       allow;
    logic [1:0] status;
    logic       used_default;
  } result_t;

  // Leading-ones mask over {high, low} for a prefix of the given family.
  function automatic logic [127:0] prefix_mask(logic v6, logic [7:0] p);
    logic [6:0]  ph;
    logic [6:0]  pl;
    logic [5:0]  p4;
    logic [63:0] mh;
    logic [63:0] ml;
    ph = (p > 8'd64) ? 7'd64 : p[6:0];
    pl = (p > 8'd64) ? 7'(p - 8'd64) : 7'd0;
    p4 = (p > 8'd32) ? 6'd32 : p[5:0];
    if (v6) begin
      mh = ~({64{1'b1}} >> ph);
      ml = ~({64{1'b1}} >> pl);
    end else begin
      mh = '0;
      ml = {32'd0, ~({32{1'b1}} >> p4)};
    end
    return {mh, ml};
  endfunction

endpackage

>>> rtl/cfma_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfma_req_if
// Request channel: check or add-rule items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfma_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [1:0]  addr_family;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic        prefix_given;
  logic [7:0]  prefix_len;
  logic        rule_allow;

  modport source (
    output valid, cmd, addr_family, addr_high, addr_low, prefix_given, prefix_len,
           rule_allow,
    input  ready
  );
  modport sink (
    input  valid, cmd, addr_family, addr_high, addr_low, prefix_given, prefix_len,
           rule_allow,
    output ready
  );
endinterface

>>> rtl/cfma_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfma_rsp_if
// Response channel: decision and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfma_rsp_if;
  logic       valid;
  logic       ready;
  logic       allow;
  logic [1:0] status;
  logic       used_default;

  modport source (
    output valid, allow, status, used_default,
    input  ready
  );
  modport sink (
    input  valid, allow, status, used_default,
    output ready
  );
endinterface

>>> rtl/cfma_rule_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfma_rule_mem
// Rule table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfma_rule_mem #(
  parameter int Depth = 16,
  parameter int IdxW  = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  cfma_pkg::rule_t  wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output cfma_pkg::rule_t  rdata_o
);
  import cfma_pkg::*;

  rule_t mem_q [Depth];
  rule_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cfma_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfma_match
// Compares a request address against one stored rule under its prefix.
// ----------------------------------------------------------------------------
module cfma_match (
  input  cfma_pkg::rule_t rule_i,
  input  logic            v6_i,
  input  logic [63:0]     addr_high_i,
  input  logic [63:0]     addr_low_i,
  output logic            hit_o
);
  import cfma_pkg::*;

  logic [127:0] mask;

  assign mask  = prefix_mask(rule_i.is_v6, rule_i.prefix);
  // family must agree, then the masked address must equal the stored network
  assign hit_o = (rule_i.is_v6 == v6_i)
              && ((addr_high_i & mask[127:64]) == rule_i.net_high)
              && ((addr_low_i  & mask[63:0])   == rule_i.net_low);

endmodule

>>> rtl/cidr_first_match_acl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cidr_first_match_acl
// First-match IPv4/IPv6 CIDR access list with an appendable rule table.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  req_i    | in  | valid/ready        | cmd, family, address, prefix, action
//  rsp_o    | out | valid/ready        | allow, status, used_default
//  cfg      | in  | cfg_we_i, no wait  | dflt_allow (default verdict)
//
//  Add request: from one accept to the next it passes the accept, execute
//  and done states; the response register loads at the end of the done cycle.
//  Check request: the scan reads one rule per cycle from the table memory
//  port and stops at the first hit or at the last held rule.
//  Reset clears the rule count and the default verdict; table contents are
//  undefined until written, and reads beyond the count are never used.
//  A taken response frees the output register; a new request is accepted
//  while the previous response still waits.
// ----------------------------------------------------------------------------
module cidr_first_match_acl #(
  parameter int MAX_RULES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  cfma_req_if.sink   req_i,
  cfma_rsp_if.source rsp_o
);
  import cfma_pkg::*;

  localparam int IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CntW = $clog2(MAX_RULES + 1);

  state_e state_q, state_d;

  logic            dflt_allow_q;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] ptr_q, ptr_d;

  // latched request
  logic        cmd_q;
  logic [1:0]  fam_q;
  logic        v6_q;
  logic [63:0] ah_q;
  logic [63:0] al_q;
  logic [7:0]  plen_q;
  logic        ract_q;

  result_t res_q, res_d;
  result_t out_q;
  logic    out_valid_q;

  logic            req_fire;
  logic            out_free;
  logic            req_v6;
  logic [7:0]      req_full;

  logic            mem_we;
  rule_t           mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  rule_t           mem_rdata;
  logic            hit;
  logic            scan_last;
  logic [127:0]    add_mask;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_v6      = (req_i.addr_family == FAM_V6);
  assign req_full    = req_v6 ? FULL_LEN_V6 : FULL_LEN_V4;

  assign scan_last = ((CntW'(ptr_q) + CntW'(1)) == count_q);
  assign add_mask  = prefix_mask(v6_q, plen_q);

  // ---- table and comparator -------------------------------------------------
  cfma_rule_mem #(
    .Depth (MAX_RULES),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cfma_match u_match (
    .rule_i      (mem_rdata),
    .v6_i        (v6_q),
    .addr_high_i (ah_q),
    .addr_low_i  (al_q),
    .hit_o       (hit)
  );

  // ---- next state -----------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        // a check with a valid family and a non-empty table goes scanning
        if (cmd_q == CMD_CHECK && fam_q <= FAM_V6 && count_q != '0) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (hit || scan_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- datapath control -----------------------------------------------------
  always_comb begin
    count_d   = count_q;
    ptr_d     = ptr_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_wdata = '{net_high: ah_q & add_mask[127:64],
                  net_low:  al_q & add_mask[63:0],
                  prefix:   plen_q,
                  is_v6:    v6_q,
                  action:   ract_q};
    mem_raddr = (state_q == ST_SCAN) ? ptr_q + IdxW'(1) : '0;
    case (state_q)
      ST_EXEC: begin
        ptr_d = '0;
        if (cmd_q == CMD_ADD) begin
          res_d = '{allow: 1'b0, status: STATUS_OK, used_default: 1'b0};
          if (count_q >= CntW'(MAX_RULES)) begin
            res_d.status = STATUS_FULL;
          end else if (fam_q > FAM_V6) begin
            res_d.status = STATUS_BAD_ADDR;
          end else if (plen_q > (v6_q ? FULL_LEN_V6 : FULL_LEN_V4)) begin
            res_d.status = STATUS_PREFIX;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end else if (fam_q > FAM_V6) begin
          res_d = '{allow: dflt_allow_q, status: STATUS_BAD_ADDR, used_default: 1'b1};
        end else begin
          // empty table answers with the default; otherwise the scan overwrites
          res_d = '{allow: dflt_allow_q, status: STATUS_OK, used_default: 1'b1};
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_d = '{allow: mem_rdata.action, status: STATUS_OK, used_default: 1'b0};
        end else if (scan_last) begin
          res_d = '{allow: dflt_allow_q, status: STATUS_OK, used_default: 1'b1};
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end
      default: ;
    endcase
  end

  // ---- registers ------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      dflt_allow_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) dflt_allow_q <= cfg_wdata_i;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    res_q <= res_d;
    if (state_q == ST_DONE && out_free) out_q <= res_q;
    if (req_fire) begin
      cmd_q  <= req_i.cmd;
      fam_q  <= req_i.addr_family;
      v6_q   <= req_v6;
      // IPv4 keeps only the low 32 address bits
      ah_q   <= req_v6 ? req_i.addr_high : 64'd0;
      al_q   <= req_v6 ? req_i.addr_low : {32'd0, req_i.addr_low[31:0]};
      plen_q <= req_i.prefix_given ? req_i.prefix_len : req_full;
      ract_q <= req_i.rule_allow;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.allow        = out_q.allow;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.used_default = out_q.used_default;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-match CIDR access list: add-rule and check
// requests are fed through the request channel with random gaps. An in-bench
// rule table predicts each verdict, and the response channel, stalled at
// random, is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import cfma_pkg::*;

  localparam int          ACL_DEPTH   = 16;
  localparam logic [1:0]  FAM_BAD     = 2'd2;   // empty or unparseable address
  localparam logic [1:0]  FAM_BAD_ALT = 2'd3;   // unused family code, also invalid
  localparam logic        ACT_DENY    = 1'b0;
  localparam logic        ACT_ALLOW   = 1'b1;
  localparam int          PHASES      = 6;
  localparam int          PHASE_REQS  = 320;

  // One request as it travels on the request channel.
  typedef struct packed {
    logic        cmd;
    logic [1:0]  family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        prefix_given;
    logic [7:0]  prefix_len;
    logic        rule_allow;
  } acl_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Bench-owned drive registers; initialised so every input is known at time 0.
  logic     cfg_we    = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     drv_valid = 1'b0;
  acl_req_t drv_req   = '0;
  logic     sink_ready = 1'b0;

  cfma_req_if req_if ();
  cfma_rsp_if rsp_if ();

  assign req_if.valid        = drv_valid;
  assign req_if.cmd          = drv_req.cmd;
  assign req_if.addr_family  = drv_req.family;
  assign req_if.addr_high    = drv_req.addr_high;
  assign req_if.addr_low     = drv_req.addr_low;
  assign req_if.prefix_given = drv_req.prefix_given;
  assign req_if.prefix_len   = drv_req.prefix_len;
  assign req_if.rule_allow   = drv_req.rule_allow;
  assign rsp_if.ready        = sink_ready;

  cidr_first_match_acl #(
    .MAX_RULES (ACL_DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Verdict predictor: its own copy of the rule table and of the default verdict.
  // --------------------------------------------------------------------------
  logic [127:0] acl_net [ACL_DEPTH];
  logic [7:0]   acl_len [ACL_DEPTH];
  logic         acl_v6  [ACL_DEPTH];
  logic         acl_act [ACL_DEPTH];
  int unsigned  acl_count    = 0;
  logic         dflt_allow   = 1'b0;

  // Coverage tallies for the closing summary
  int unsigned  n_checks     = 0;
  int unsigned  n_adds       = 0;
  int unsigned  n_rule_hits  = 0;
  int unsigned  n_dflt       = 0;
  int unsigned  status_tally [4] = '{default: 0};
  int unsigned  err_cnt      = 0;

  // Leading-ones mask over the 128-bit address; IPv4 lives in the low 32 bits.
  // A shift by the full width yields zero, which covers a zero-length prefix.
  function automatic logic [127:0] net_mask(logic v6, logic [7:0] len);
    logic [127:0] ones;
    ones = '1;
    if (v6) return ones << (9'd128 - len);
    return {96'd0, ones[31:0] << (6'd32 - len[5:0])};
  endfunction

  // Address as the block sees it: IPv4 drops addr_high and addr_low[63:32].
  function automatic logic [127:0] req_addr(acl_req_t rq);
    if (rq.family == FAM_V6) return {rq.addr_high, rq.addr_low};
    return {96'd0, rq.addr_low[31:0]};
  endfunction

  function automatic result_t acl_decide(acl_req_t rq);
    result_t      verdict;
    logic         v6;
    logic [127:0] a;
    logic [7:0]   full_len;
    logic [7:0]   len;
    verdict = '0;
    v6 = (rq.family == FAM_V6);
    a = req_addr(rq);
    if (rq.cmd == CMD_ADD) begin
      n_adds++;
      full_len = v6 ? FULL_LEN_V6 : FULL_LEN_V4;
      len = rq.prefix_given ? rq.prefix_len : full_len;
      // table full wins over every other error
      if (acl_count >= ACL_DEPTH) begin
        verdict.status = STATUS_FULL;
      end else if (rq.family > FAM_V6) begin
        verdict.status = STATUS_BAD_ADDR;
      end else if (len > full_len) begin
        verdict.status = STATUS_PREFIX;
      end else begin
        acl_net[acl_count] = a & net_mask(v6, len);
        acl_len[acl_count] = len;
        acl_v6[acl_count]  = v6;
        acl_act[acl_count] = rq.rule_allow;
        acl_count++;
      end
      status_tally[verdict.status]++;
      return verdict;
    end
    n_checks++;
    if (rq.family > FAM_V6) begin
      verdict.allow        = dflt_allow;
      verdict.status       = STATUS_BAD_ADDR;
      verdict.used_default = 1'b1;
      status_tally[verdict.status]++;
      return verdict;
    end
    // first rule of the same family whose network covers the address decides
    for (int i = 0; i < acl_count; i++) begin
      if (acl_v6[i] == v6 && (a & net_mask(v6, acl_len[i])) == acl_net[i]) begin
        verdict.allow = acl_act[i];
        n_rule_hits++;
        status_tally[verdict.status]++;
        return verdict;
      end
    end
    verdict.allow        = dflt_allow;
    verdict.used_default = 1'b1;
    n_dflt++;
    status_tally[verdict.status]++;
    return verdict;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: pops the backlog, idles a drawn number of cycles between
  // requests, and predicts the verdict of each request at its acceptance.
  // --------------------------------------------------------------------------
  acl_req_t    req_backlog [$];
  result_t     verdict_q   [$];
  int unsigned src_gap_max = 0;
  int unsigned snk_gap_max = 0;
  int unsigned src_wait    = 0;
  int unsigned snk_wait    = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    acl_req_t nxt;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      src_wait  <= 0;
    end else begin
      if (drv_valid && req_if.ready) begin
        verdict_q.push_back(acl_decide(drv_req));
      end
      // slot is free once nothing is offered or the offer was just taken
      if (!drv_valid || req_if.ready) begin
        if (src_wait != 0) begin
          src_wait  <= src_wait - 1;
          drv_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          nxt = req_backlog.pop_front();
          drv_req   <= nxt;
          drv_valid <= 1'b1;
          src_wait  <= $urandom_range(0, src_gap_max);
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor: random stalls on ready; each taken response is checked
  // against the oldest predicted verdict.
  // --------------------------------------------------------------------------
  task automatic flag_field(string field, logic [1:0] want, logic [1:0] got);
    err_cnt++;
    $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall;
    result_t     want;
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      snk_wait   <= 0;
    end else begin
      stall = snk_wait;
      if (rsp_if.valid && sink_ready) begin
        if (verdict_q.size() == 0) begin
          err_cnt++;
          $display("%0t ns: response with none expected (allow %0b status %0d default %0b)",
                   $time, rsp_if.allow, rsp_if.status, rsp_if.used_default);
        end else begin
          want = verdict_q.pop_front();
          if (rsp_if.allow !== want.allow)
            flag_field("allow", want.allow, rsp_if.allow);
          if (rsp_if.status !== want.status)
            flag_field("status", want.status, rsp_if.status);
          if (rsp_if.used_default !== want.used_default)
            flag_field("used_default", want.used_default, rsp_if.used_default);
        end
        stall = $urandom_range(0, snk_gap_max);
      end
      if (stall != 0) begin
        sink_ready <= 1'b0;
        snk_wait   <= stall - 1;
      end else begin
        sink_ready <= 1'b1;
        snk_wait   <= 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. The generator keeps its own list of the rules it has planned so
  // that check addresses can be aimed inside, or just outside, real networks.
  // --------------------------------------------------------------------------
  logic [127:0] gen_net [ACL_DEPTH];
  logic [7:0]   gen_len [ACL_DEPTH];
  logic         gen_v6  [ACL_DEPTH];
  int unsigned  gen_n = 0;

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void plan_rule(logic v6, logic [127:0] a, logic [7:0] len);
    gen_net[gen_n] = a & net_mask(v6, len);
    gen_len[gen_n] = len;
    gen_v6[gen_n]  = v6;
    gen_n++;
  endfunction

  // Puts an address into a request; IPv4 keeps the random junk above bit 31.
  function automatic acl_req_t place_addr(acl_req_t rq, logic v6, logic [127:0] a);
    if (v6) {rq.addr_high, rq.addr_low} = a;
    else rq.addr_low[31:0] = a[31:0];
    return rq;
  endfunction

  function automatic acl_req_t mk_req(logic cmd, logic [1:0] fam, logic [63:0] hi,
                                      logic [63:0] lo, logic given, logic [7:0] plen,
                                      logic act);
    acl_req_t rq;
    rq.cmd          = cmd;
    rq.family       = fam;
    rq.addr_high    = hi;
    rq.addr_low     = lo;
    rq.prefix_given = given;
    rq.prefix_len   = plen;
    rq.rule_allow   = act;
    return rq;
  endfunction

  // Valid add: queued and recorded in the generator's rule list.
  task automatic queue_rule(logic [1:0] fam, logic [63:0] hi, logic [63:0] lo,
                            logic given, logic [7:0] plen, logic act);
    acl_req_t rq;
    rq = mk_req(CMD_ADD, fam, hi, lo, given, plen, act);
    plan_rule(fam == FAM_V6, req_addr(rq),
              given ? plen : (fam == FAM_V6 ? FULL_LEN_V6 : FULL_LEN_V4));
    req_backlog.push_back(rq);
  endtask

  function automatic acl_req_t rand_req();
    acl_req_t     rq;
    int unsigned  roll;
    int unsigned  sel;
    int unsigned  k;
    logic         v6;
    logic [7:0]   full_len;
    logic [7:0]   len;
    logic [127:0] a;
    rq = mk_req(CMD_CHECK, FAM_V4, rnd64(), rnd64(), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    roll = $urandom_range(0, 999);
    sel  = $urandom_range(0, 99);
    if (roll < 10) begin
      // well-formed add, slow enough that the table fills near mid-run
      rq.cmd = CMD_ADD;
      if (gen_n >= ACL_DEPTH) begin
        rq.family = 2'($urandom_range(FAM_V4, FAM_BAD_ALT));
        return rq;
      end
      // the last two rules are catch-alls, so earlier rules stay reachable
      if (gen_n == ACL_DEPTH - 2) begin
        v6 = 1'b1;
        len = 8'd0;
      end else if (gen_n == ACL_DEPTH - 1) begin
        v6 = 1'b0;
        len = 8'd0;
      end else begin
        v6 = 1'($urandom_range(0, 1));
        len = 8'($urandom_range(1, v6 ? FULL_LEN_V6 : FULL_LEN_V4));
      end
      full_len  = v6 ? FULL_LEN_V6 : FULL_LEN_V4;
      rq.family = v6 ? FAM_V6 : FAM_V4;
      // nest inside an existing network now and then to test rule order
      if (gen_n != 0) begin
        k = $urandom_range(0, gen_n - 1);
        if (gen_v6[k] == v6 && sel < 50) begin
          a = gen_net[k] | ({rnd64(), rnd64()} & ~net_mask(v6, gen_len[k]));
          rq = place_addr(rq, v6, a);
        end
      end
      if (len == full_len && sel[0]) begin
        rq.prefix_given = 1'b0;
      end else begin
        rq.prefix_given = 1'b1;
        rq.prefix_len   = len;
      end
      plan_rule(v6, req_addr(rq), len);
    end else if (roll < 50 || (gen_n >= ACL_DEPTH && roll < 80)) begin
      // broken add: bad family or over-long prefix (table full once it is)
      rq.cmd = CMD_ADD;
      if (sel < 50) begin
        rq.family = 2'($urandom_range(FAM_BAD, FAM_BAD_ALT));
      end else begin
        rq.family       = 2'($urandom_range(FAM_V4, FAM_V6));
        rq.prefix_given = 1'b1;
        rq.prefix_len   = 8'($urandom_range(
                            (rq.family == FAM_V6 ? FULL_LEN_V6 : FULL_LEN_V4) + 1, 255));
      end
    end else if (sel < 6) begin
      rq.family = 2'($urandom_range(FAM_BAD, FAM_BAD_ALT));
    end else if (gen_n != 0 && sel < 80) begin
      // aimed check: host bits random, sometimes one network bit flipped
      k  = $urandom_range(0, gen_n - 1);
      v6 = gen_v6[k];
      a  = gen_net[k] | ({rnd64(), rnd64()} & ~net_mask(v6, gen_len[k]));
      if (sel < 30 && gen_len[k] != 0) begin
        a[(v6 ? 127 : 31) - $urandom_range(0, gen_len[k] - 1)] ^= 1'b1;
      end
      rq.family = v6 ? FAM_V6 : FAM_V4;
      rq = place_addr(rq, v6, a);
    end else begin
      rq.family = 2'($urandom_range(FAM_V4, FAM_V6));
    end
    return rq;
  endfunction

  // Block is idle once nothing waits to be sent, offered or answered.
  task automatic wait_drained();
    while (req_backlog.size() != 0 || drv_valid || verdict_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_dflt_allow(logic v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    dflt_allow = v;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, default deny
    src_gap_max = 2;
    snk_gap_max = 2;
    set_dflt_allow(1'b0);
    @(negedge clk_i);
    // empty table, then both invalid family codes on a check
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_V4, '1, 64'hFFFF_FFFF_C0A8_0001, 1'b1,
                                 8'hFF, ACT_ALLOW));
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_BAD, rnd64(), rnd64(), 1'b0, 8'h00,
                                 ACT_DENY));
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_BAD_ALT, '1, '1, 1'b1, 8'hFF, ACT_ALLOW));
    // rejected adds: invalid family, prefix past the family length
    req_backlog.push_back(mk_req(CMD_ADD, FAM_BAD, '1, '1, 1'b1, 8'd8, ACT_ALLOW));
    req_backlog.push_back(mk_req(CMD_ADD, FAM_BAD_ALT, '0, '0, 1'b1, 8'd0, ACT_DENY));
    req_backlog.push_back(mk_req(CMD_ADD, FAM_V4, '0, 64'h0A00_0000, 1'b1, 8'd33, ACT_ALLOW));
    req_backlog.push_back(mk_req(CMD_ADD, FAM_V6, '1, '1, 1'b1, 8'd129, ACT_ALLOW));
    req_backlog.push_back(mk_req(CMD_ADD, FAM_V4, '1, '1, 1'b1, 8'hFF, ACT_ALLOW));
    // accepted adds: full length by omission (junk prefix_len) and by value
    queue_rule(FAM_V4, '1, '1, 1'b0, 8'hAA, ACT_ALLOW);
    queue_rule(FAM_V6, '1, '1, 1'b0, 8'h55, ACT_DENY);
    queue_rule(FAM_V4, '1, 64'hFFFF_FFFF_0000_0000, 1'b1, 8'd32, ACT_DENY);
    queue_rule(FAM_V6, '0, '0, 1'b1, 8'd128, ACT_ALLOW);
    queue_rule(FAM_V4, rnd64(), 64'h0000_0000_0AFF_FFFF, 1'b1, 8'd8, ACT_ALLOW);
    // /65 straddles the word boundary and shadows half of the later /64
    queue_rule(FAM_V6, 64'h2001_0DB8_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 8'd65,
               ACT_DENY);
    queue_rule(FAM_V6, 64'h2001_0DB8_0000_0000, rnd64(), 1'b1, 8'd64, ACT_ALLOW);
    // checks against the rules above
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_V4, rnd64(), 64'h1234_5678_FFFF_FFFF, 1'b0,
                                 8'h00, ACT_DENY));
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_V6, '1, '1, 1'b0, 8'h00, ACT_DENY));
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_V4, '1, 64'hFFFF_FFFF_0000_0000, 1'b1,
                                 8'hFF, ACT_ALLOW));
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_V6, '0, '0, 1'b0, 8'h00, ACT_DENY));
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_V4, '0, 64'h0A12_3456, 1'b0, 8'h00,
                                 ACT_DENY));
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_V4, '0, 64'h0B00_0000, 1'b0, 8'h00,
                                 ACT_DENY));
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_V6, 64'h2001_0DB8_0000_0000,
                                 64'hC000_0000_0000_0001, 1'b0, 8'h00, ACT_DENY));
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_V6, 64'h2001_0DB8_0000_0000,
                                 64'h0000_0000_0000_1234, 1'b0, 8'h00, ACT_DENY));
    req_backlog.push_back(mk_req(CMD_CHECK, FAM_V6, 64'h2001_0DB9_0000_0000, '0, 1'b0,
                                 8'h00, ACT_DENY));
    wait_drained();

    // Random phases; the default verdict and the idle pattern change at each
    // boundary, and the sender holds off until the block has drained.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          src_gap_max = 3;
          snk_gap_max = 3;
        end
        1: begin
          src_gap_max = 0;
          snk_gap_max = 0;
        end
        2: begin
          src_gap_max = 16;
          snk_gap_max = 0;
        end
        3: begin
          src_gap_max = 0;
          snk_gap_max = 16;
        end
        4: begin
          src_gap_max = 16;
          snk_gap_max = 16;
        end
        default: begin
          src_gap_max = $urandom_range(0, 16);
          snk_gap_max = $urandom_range(0, 16);
        end
      endcase
      set_dflt_allow(ph == PHASES - 1 ? 1'($urandom_range(0, 1)) : !ph[0]);
      @(negedge clk_i);
      for (int n = 0; n < PHASE_REQS; n++) req_backlog.push_back(rand_req());
      wait_drained();
    end
    repeat (ACL_DEPTH + 8) @(posedge clk_i);

    $display("Requests: %0d checks (%0d rule hits, %0d default), %0d adds, %0d rules held",
             n_checks, n_rule_hits, n_dflt, n_adds, acl_count);
    $display("Status seen: ok %0d, table full %0d, prefix too long %0d, invalid address %0d",
             status_tally[STATUS_OK], status_tally[STATUS_FULL], status_tally[STATUS_PREFIX],
             status_tally[STATUS_BAD_ADDR]);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("cidr_first_match_acl: match");
    end else begin
      $display("cidr_first_match_acl: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("cidr_first_match_acl: mismatch");
    $finish;
  end

endmodule
